/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/nns_pkg.sv */
// ----------------------------------------------------------------------------
// Scaler package
// Shared types, constants and the helper function of the image scaler.
// ----------------------------------------------------------------------------
package nns_pkg;

    localparam int DIM_W    = 12;
    localparam int SIZE_W   = 13;
    localparam int PIX_W    = 32;
    localparam int PROD_W   = 25;
    localparam int SUM_W    = 26;
    localparam int DEN_W    = 12;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;
    localparam logic [SIZE_W-1:0] DST_MIN  = 13'd2;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TOO_SMALL = 1'b1;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_LEFT       = 3'd4,
        REG_TOP        = 3'd5,
        REG_STRIDE     = 3'd6,
        REG_WIDE       = 3'd7
    } reg_idx_t;

    typedef enum logic [0:0] {
        CMD_WRITE   = 1'b0,
        CMD_REQUEST = 1'b1
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_READ,
        ST_OUT
    } st_t;

    typedef struct packed {
        logic [SIZE_W-1:0] src_width;
        logic [SIZE_W-1:0] src_height;
        logic [SIZE_W-1:0] dst_width;
        logic [SIZE_W-1:0] dst_height;
        logic [DIM_W-1:0]  left_offset;
        logic [DIM_W-1:0]  top_offset;
        logic [DIM_W-1:0]  row_stride;
        logic              wide_pixels;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [DIM_W-1:0]  index;
        logic [PIX_W-1:0]  pixel;
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_out;
        logic [DIM_W-1:0]  dest_x;
        logic [DIM_W-1:0]  dest_y;
        logic              row_end;
        logic              frame_end;
        logic              status;
    } res_t;

    localparam cfg_t CFG_RESET = '{
        src_width:   13'd1,
        src_height:  13'd1,
        dst_width:   13'd0,
        dst_height:  13'd0,
        left_offset: 12'd0,
        top_offset:  12'd0,
        row_stride:  12'd0,
        wide_pixels: 1'b0
    };

    localparam res_t RES_TOO_SMALL = '{
        pixel_out: 32'd0,
        dest_x:    12'd0,
        dest_y:    12'd0,
        row_end:   1'b0,
        frame_end: 1'b0,
        status:    STATUS_TOO_SMALL
    };

    // Size minus one with zero taken as one and oversized values capped.
    function automatic logic [DIM_W-1:0] size_m1(input logic [SIZE_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (v > SIZE_MAX) begin
            r = '1;
        end else begin
            r = DIM_W'(v - 13'd1);
        end
        return r;
    endfunction

endpackage

/* src/nearest_neighbor_image_scaler.sv */
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler: a write beat passes through the front-end queue before it updates the store.
// Writes run at one beat per cycle while the back end is free; a request holds the back end through MUL, READ and OUT.
// A request with steps ready passes the queue and the MUL, READ and OUT states before its result is valid.
// The first request of a frame also waits in the DIV state for the step dividers.
// Synchronous active-low reset clears config, queue and frame state; the store is not cleared.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler #(
    parameter int STORE_DEPTH   = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nns_pkg::PADDR_W-1:0]   paddr,
    input  logic [nns_pkg::PDATA_W-1:0]   pwdata,
    output logic [nns_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // write_index [11:0], write_pixel [43:12], zero [47:44]
    input  logic [47:0]                   s_tdata,
    // req_type [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_out [31:0], dest_x [43:32], dest_y [55:44], row_end [56], zero [63:57]
    output logic [63:0]                   m_tdata,
    // frame_end
    output logic                          m_tlast,
    // status [0]
    output logic                          m_tuser
);

    nns_pkg::cfg_t cfg;
    nns_pkg::cmd_t q_entry;
    nns_pkg::res_t out_data;
    logic          q_valid, q_pop;

    nns_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nns_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser),
        .write_index (s_tdata[11:0]),
        .write_pixel (s_tdata[43:12]),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop)
    );

    nns_back #(
        .STORE_DEPTH   (STORE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = {7'd0, out_data.row_end, out_data.dest_y, out_data.dest_x,
                      out_data.pixel_out};
    assign m_tlast = out_data.frame_end;
    assign m_tuser = out_data.status;

endmodule

/* src/nns_regs.sv */
// ----------------------------------------------------------------------------
// Scaler configuration registers
// APB register file holding the source region and destination geometry.
// ----------------------------------------------------------------------------
module nns_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nns_pkg::PADDR_W-1:0]   paddr,
    input  logic [nns_pkg::PDATA_W-1:0]   pwdata,
    output logic [nns_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output nns_pkg::cfg_t                 cfg
);

    nns_pkg::cfg_t     cfg_reg;
    nns_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = nns_pkg::reg_idx_t'(paddr[nns_pkg::PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= nns_pkg::CFG_RESET;
        end else if (wr_en) begin
            unique case (idx)
                nns_pkg::REG_SRC_WIDTH:  cfg_reg.src_width   <= pwdata[nns_pkg::SIZE_W-1:0];
                nns_pkg::REG_SRC_HEIGHT: cfg_reg.src_height  <= pwdata[nns_pkg::SIZE_W-1:0];
                nns_pkg::REG_DST_WIDTH:  cfg_reg.dst_width   <= pwdata[nns_pkg::SIZE_W-1:0];
                nns_pkg::REG_DST_HEIGHT: cfg_reg.dst_height  <= pwdata[nns_pkg::SIZE_W-1:0];
                nns_pkg::REG_LEFT:       cfg_reg.left_offset <= pwdata[nns_pkg::DIM_W-1:0];
                nns_pkg::REG_TOP:        cfg_reg.top_offset  <= pwdata[nns_pkg::DIM_W-1:0];
                nns_pkg::REG_STRIDE:     cfg_reg.row_stride  <= pwdata[nns_pkg::DIM_W-1:0];
                nns_pkg::REG_WIDE:       cfg_reg.wide_pixels <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            nns_pkg::REG_SRC_WIDTH:  prdata = nns_pkg::PDATA_W'(cfg_reg.src_width);
            nns_pkg::REG_SRC_HEIGHT: prdata = nns_pkg::PDATA_W'(cfg_reg.src_height);
            nns_pkg::REG_DST_WIDTH:  prdata = nns_pkg::PDATA_W'(cfg_reg.dst_width);
            nns_pkg::REG_DST_HEIGHT: prdata = nns_pkg::PDATA_W'(cfg_reg.dst_height);
            nns_pkg::REG_LEFT:       prdata = nns_pkg::PDATA_W'(cfg_reg.left_offset);
            nns_pkg::REG_TOP:        prdata = nns_pkg::PDATA_W'(cfg_reg.top_offset);
            nns_pkg::REG_STRIDE:     prdata = nns_pkg::PDATA_W'(cfg_reg.row_stride);
            nns_pkg::REG_WIDE:       prdata = nns_pkg::PDATA_W'(cfg_reg.wide_pixels);
        endcase
    end

endmodule

/* src/nns_front.sv */
// ----------------------------------------------------------------------------
// Scaler front end
// Accepts input beats, tags them as store writes or pixel requests and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nns_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic                         req_type,
    input  logic [nns_pkg::DIM_W-1:0]    write_index,
    input  logic [nns_pkg::PIX_W-1:0]    write_pixel,
    output logic                         q_valid,
    output nns_pkg::cmd_t                q_entry,
    input  logic                         q_pop
);

    nns_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push;
    nns_pkg::cmd_t cmd_in;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;

    always_comb begin
        cmd_in.kind  = req_type ? nns_pkg::CMD_REQUEST : nns_pkg::CMD_WRITE;
        cmd_in.index = write_index;
        cmd_in.pixel = write_pixel;
    end

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* src/nns_div.sv */
// ----------------------------------------------------------------------------
// Scaler step divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nns_div #(
    parameter int NUM_W = 28
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [NUM_W-1:0]             num,
    input  logic [nns_pkg::DEN_W-1:0]    den,
    output logic                         busy,
    output logic                         done,
    output logic [NUM_W-1:0]             quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [NUM_W-1:0]          quo_reg, quo_next;
    logic [nns_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [nns_pkg::DEN_W-1:0] den_reg;
    logic [nns_pkg::DEN_W:0]   shifted;
    logic                      bit_ok;

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quo  = quo_reg;

    always_comb begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        bit_ok    = (shifted >= {1'b0, den_reg});
        rem_next  = bit_ok ? nns_pkg::DEN_W'(shifted - {1'b0, den_reg})
                           : shifted[nns_pkg::DEN_W-1:0];
        quo_next  = {quo_reg[NUM_W-2:0], bit_ok};
        cnt_next  = busy ? cnt_reg - CNT_W'(1) : cnt_reg;
        done_next = (cnt_reg == CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(NUM_W);
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

/* src/nns_back.sv */
// ----------------------------------------------------------------------------
// Scaler back end
// Executes queued commands: store writes, step division at frame start,
// source address generation, store read, too-small status results and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nns_back #(
    parameter int STORE_DEPTH   = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  nns_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  nns_pkg::cmd_t    q_entry,
    output logic             q_pop,
    output logic             out_valid,
    output nns_pkg::res_t    out_data,
    input  logic             out_ready
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int ACC_W  = FRACTION_BITS + nns_pkg::DIM_W;

    nns_pkg::st_t state_reg, state_next;

    logic [nns_pkg::PIX_W-1:0]  store_mem [STORE_DEPTH];
    logic [nns_pkg::PIX_W-1:0]  rd_data_reg;
    logic [ACC_W-1:0]           x_step_reg, y_step_reg;
    logic [ACC_W-1:0]           x_acc_reg, y_acc_reg;
    logic [nns_pkg::DIM_W-1:0]  col_reg, row_reg;
    logic                       steps_ready_reg;
    logic [nns_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                       out_valid_reg;
    nns_pkg::res_t              out_reg, res_next;

    logic                       too_small, out_free;
    logic                       mem_we, rd_en, div_start, small_load, out_load;
    logic [nns_pkg::DIM_W-1:0]  dw_m1, dh_m1, xint, yint;
    logic [nns_pkg::SIZE_W-1:0] row_sum;
    logic [nns_pkg::SUM_W-1:0]  addr_sum, widx_ext;
    logic [ADDR_W-1:0]          raddr, waddr;
    logic [ACC_W-1:0]           num_x, num_y, quo_x, quo_y;
    logic                       div_x_busy, div_x_done, div_y_busy, div_y_done;
    logic                       rend, fend;

    assign too_small = (cfg.dst_width < nns_pkg::DST_MIN)
                    || (cfg.dst_height < nns_pkg::DST_MIN);
    assign out_free  = !out_valid_reg || out_ready;
    assign dw_m1     = nns_pkg::size_m1(cfg.dst_width);
    assign dh_m1     = nns_pkg::size_m1(cfg.dst_height);
    assign num_x     = {nns_pkg::size_m1(cfg.src_width), {FRACTION_BITS{1'b0}}};
    assign num_y     = {nns_pkg::size_m1(cfg.src_height), {FRACTION_BITS{1'b0}}};
    assign xint      = x_acc_reg[ACC_W-1:FRACTION_BITS];
    assign yint      = y_acc_reg[ACC_W-1:FRACTION_BITS];
    assign row_sum   = nns_pkg::SIZE_W'(yint) + nns_pkg::SIZE_W'(cfg.top_offset);
    assign prod_next = nns_pkg::PROD_W'(row_sum) * nns_pkg::PROD_W'(cfg.row_stride);
    assign addr_sum  = nns_pkg::SUM_W'(cfg.left_offset) + nns_pkg::SUM_W'(xint)
                     + nns_pkg::SUM_W'(prod_reg);
    assign raddr     = addr_sum[ADDR_W-1:0];
    assign widx_ext  = nns_pkg::SUM_W'(q_entry.index);
    assign waddr     = widx_ext[ADDR_W-1:0];
    assign rend      = (col_reg >= dw_m1);
    assign fend      = rend && (row_reg >= dh_m1);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    nns_div #(.NUM_W(ACC_W)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_x),
        .den     (dw_m1),
        .busy    (div_x_busy),
        .done    (div_x_done),
        .quo     (quo_x)
    );

    nns_div #(.NUM_W(ACC_W)) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_y),
        .den     (dh_m1),
        .busy    (div_y_busy),
        .done    (div_y_done),
        .quo     (quo_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nns_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        div_start  = 1'b0;
        small_load = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            nns_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (q_entry.kind == nns_pkg::CMD_WRITE) begin
                        q_pop  = 1'b1;
                        mem_we = 1'b1;
                    end else if (too_small) begin
                        if (out_free) begin
                            q_pop      = 1'b1;
                            small_load = 1'b1;
                        end
                    end else if (!steps_ready_reg) begin
                        q_pop      = 1'b1;
                        div_start  = 1'b1;
                        state_next = nns_pkg::ST_DIV;
                    end else begin
                        q_pop      = 1'b1;
                        state_next = nns_pkg::ST_MUL;
                    end
                end
            end
            nns_pkg::ST_DIV: begin
                if (div_x_done) begin
                    state_next = nns_pkg::ST_MUL;
                end
            end
            nns_pkg::ST_MUL: begin
                state_next = nns_pkg::ST_READ;
            end
            nns_pkg::ST_READ: begin
                rd_en      = 1'b1;
                state_next = nns_pkg::ST_OUT;
            end
            nns_pkg::ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = nns_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nns_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res_next           = '0;
        res_next.pixel_out = cfg.wide_pixels ? rd_data_reg
                                             : {24'd0, rd_data_reg[7:0]};
        res_next.dest_x    = col_reg;
        res_next.dest_y    = row_reg;
        res_next.row_end   = rend;
        res_next.frame_end = fend;
        res_next.status    = nns_pkg::STATUS_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_ready_reg <= 1'b0;
            x_step_reg      <= '0;
            y_step_reg      <= '0;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (small_load || (out_load && fend)) begin
                steps_ready_reg <= 1'b0;
                x_step_reg      <= '0;
                y_step_reg      <= '0;
                x_acc_reg       <= '0;
                y_acc_reg       <= '0;
                col_reg         <= '0;
                row_reg         <= '0;
            end else if (state_reg == nns_pkg::ST_DIV && div_x_done) begin
                steps_ready_reg <= 1'b1;
                x_step_reg      <= quo_x;
                y_step_reg      <= quo_y;
                x_acc_reg       <= '0;
                y_acc_reg       <= '0;
                col_reg         <= '0;
                row_reg         <= '0;
            end else if (out_load && rend) begin
                col_reg   <= '0;
                x_acc_reg <= '0;
                row_reg   <= row_reg + nns_pkg::DIM_W'(1);
                y_acc_reg <= y_acc_reg + y_step_reg;
            end else if (out_load) begin
                col_reg   <= col_reg + nns_pkg::DIM_W'(1);
                x_acc_reg <= x_acc_reg + x_step_reg;
            end
            if (small_load || out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == nns_pkg::ST_MUL) begin
            prod_reg <= prod_next;
        end
        if (small_load) begin
            out_reg <= nns_pkg::RES_TOO_SMALL;
        end else if (out_load) begin
            out_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[waddr] <= q_entry.pixel;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[raddr];
        end
    end

    `CHK_IMPLY(a_idle_frame_clear, !steps_ready_reg,
        (col_reg == '0) && (row_reg == '0) && (x_acc_reg == '0) && (y_acc_reg == '0),
        "Frame state not cleared while steps are invalid")
    `CHK_IMPLY(a_div_active, state_reg == nns_pkg::ST_DIV, div_x_busy || div_x_done,
        "Waiting for a divider that is not running")
    `CHK_IMPLY(a_div_lockstep, div_x_done || div_x_busy,
        (div_y_done == div_x_done) && (div_y_busy == div_x_busy),
        "Step dividers out of step")
    `CHK_NEXT(a_frame_restart, out_load && fend, !steps_ready_reg,
        "Frame end did not restart the frame")

endmodule
